FILE: hdl/pfa_pkg.sv
package pfa_pkg;

    // Operation codes of an input item.
    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_ALLOC = 2'd2;

    // Fit modes. The unused code behaves as first fit.
    localparam logic [1:0] FIT_FIRST = 2'd0;
    localparam logic [1:0] FIT_WORST = 2'd1;
    localparam logic [1:0] FIT_BEST  = 2'd2;

    // Configuration register indexes.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;
    localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_BLOCKS = 2'd1;

    typedef struct packed {
        logic [1:0]  op;
        logic [3:0]  block_index;
        logic [15:0] block_size;
        logic [15:0] request_size;
    } t_in_item;

    typedef struct packed {
        logic        granted;
        logic [3:0]  block_number;
        logic [15:0] fragmentation;
    } t_out_item;

    // Broadcast command from the control to every cell.
    typedef struct packed {
        logic        load;
        logic        clear;
        logic        mark;
        logic [3:0]  load_idx;
        logic [15:0] load_size;
    } t_cell_cmd;

    // Control part of the candidate that moves down the chain.
    typedef struct packed {
        logic valid;
        logic found;
    } t_cand;

endpackage

FILE: hdl/pfa_cell.sv
module pfa_cell #(
    parameter int J          = 0,
    parameter int IDX_W      = 4,
    parameter int SIZE_WIDTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  pfa_pkg::t_cell_cmd    i_cmd,
    input  logic [IDX_W-1:0]      i_mark_idx,
    input  logic [SIZE_WIDTH-1:0] i_req,
    input  logic [1:0]            i_fit_mode,
    input  logic [4:0]            i_num_blocks,
    input  pfa_pkg::t_cand        i_cand,
    input  logic [IDX_W-1:0]      i_cand_idx,
    input  logic [SIZE_WIDTH-1:0] i_cand_size,
    output pfa_pkg::t_cand        o_cand,
    output logic [IDX_W-1:0]      o_cand_idx,
    output logic [SIZE_WIDTH-1:0] o_cand_size
);

    logic [SIZE_WIDTH-1:0] r_size;
    logic                  r_used;
    logic                  r_valid;
    logic                  r_found;
    logic [IDX_W-1:0]      r_idx;
    logic [SIZE_WIDTH-1:0] r_csize;

    logic active;
    logic fits;
    logic better;
    logic take;

    // A cell beyond the configured block count never takes the candidate.
    assign active = 32'(i_num_blocks) > J;
    assign fits   = active && !r_used && (r_size >= i_req);
    assign better = ((i_fit_mode == pfa_pkg::FIT_WORST) && (r_size > i_cand_size)) ||
                    ((i_fit_mode == pfa_pkg::FIT_BEST)  && (r_size < i_cand_size));
    assign take   = fits && (!i_cand.found || better);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && (32'(i_cmd.load_idx) == J)) begin
            r_size <= SIZE_WIDTH'(i_cmd.load_size);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cand.valid;
            if (i_cmd.clear) begin
                r_used <= 1'b0;
            end else if (i_cmd.mark && (i_mark_idx == IDX_W'(J))) begin
                r_used <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cand.valid) begin
            r_found <= i_cand.found || take;
            if (take) begin
                r_idx   <= IDX_W'(J);
                r_csize <= r_size;
            end else begin
                r_idx   <= i_cand_idx;
                r_csize <= i_cand_size;
            end
        end
    end

    assign o_cand.valid = r_valid;
    assign o_cand.found = r_found;
    assign o_cand_idx   = r_idx;
    assign o_cand_size  = r_csize;

endmodule

FILE: hdl/partition_fit_allocator.sv
// Fixed-partition allocator built as a chain of MAX_BLOCKS cells, one per
// table block; each cell holds its block size and in-use flag. Load and clear
// items take effect in the cycle of their transfer and give no result. An
// allocate item launches a candidate that moves one cell per clock down the
// chain from the go register through each cell register; the done state then
// moves the result to the output register and returns to idle, and the chain
// length sets how long a request takes. While a request
// is in the chain the input is stalled. A finished result waits in the output
// register, and the block takes the next input item meanwhile. Configuration
// writes are always ready and must only be made while the block is idle.
module partition_fit_allocator #(
    parameter int MAX_BLOCKS = 16,
    parameter int SIZE_WIDTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  pfa_pkg::t_in_item                   i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output pfa_pkg::t_out_item                  o_out_data,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [pfa_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [pfa_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state                r_state;
    t_state                n_state;
    logic [1:0]            r_fit_mode;
    logic [4:0]            r_num_blocks;
    logic [SIZE_WIDTH-1:0] r_req;
    logic                  r_go;
    logic                  r_out_valid;
    pfa_pkg::t_out_item    r_out_data;

    logic                  in_xfer;
    logic                  out_free;
    logic                  finish;
    pfa_pkg::t_cell_cmd    cmd;
    logic [IDX_W-1:0]      mark_idx;
    logic [SIZE_WIDTH-1:0] frag_full;

    // Candidate chain: entry j feeds cell j, the last entry is the outcome.
    pfa_pkg::t_cand        c_cand [MAX_BLOCKS+1];
    logic [IDX_W-1:0]      c_idx  [MAX_BLOCKS+1];
    logic [SIZE_WIDTH-1:0] c_size [MAX_BLOCKS+1];

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign in_xfer     = i_in_valid && (r_state == S_IDLE);
    assign out_free    = !r_out_valid || !i_out_stall;
    assign finish      = (r_state == S_DONE) && out_free;

    // The candidate that enters the first cell has found nothing.
    assign c_cand[0].valid = r_go;
    assign c_cand[0].found = 1'b0;
    assign c_idx[0]        = '0;
    assign c_size[0]       = '0;

    // Broadcast command: loads and clears happen on the input transfer, the
    // chosen block is marked when its result moves to the output register.
    always_comb begin
        cmd.load      = in_xfer && (i_in_data.op == pfa_pkg::OP_LOAD);
        cmd.clear     = in_xfer && (i_in_data.op == pfa_pkg::OP_CLEAR);
        cmd.mark      = finish && c_cand[MAX_BLOCKS].found;
        cmd.load_idx  = i_in_data.block_index;
        cmd.load_size = i_in_data.block_size;
        mark_idx      = c_idx[MAX_BLOCKS];
    end

    for (genvar j = 0; j < MAX_BLOCKS; j++) begin : g_cell
        pfa_cell #(
            .J          (j),
            .IDX_W      (IDX_W),
            .SIZE_WIDTH (SIZE_WIDTH)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (cmd),
            .i_mark_idx   (mark_idx),
            .i_req        (r_req),
            .i_fit_mode   (r_fit_mode),
            .i_num_blocks (r_num_blocks),
            .i_cand       (c_cand[j]),
            .i_cand_idx   (c_idx[j]),
            .i_cand_size  (c_size[j]),
            .o_cand       (c_cand[j+1]),
            .o_cand_idx   (c_idx[j+1]),
            .o_cand_size  (c_size[j+1])
        );
    end

    // Fragmentation is the difference at the stored width, reported in 16 bits.
    assign frag_full = c_size[MAX_BLOCKS] - r_req;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer && (i_in_data.op == pfa_pkg::OP_ALLOC)) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (c_cand[MAX_BLOCKS].valid) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_fit_mode   <= pfa_pkg::FIT_FIRST;
            r_num_blocks <= 5'd16;
            r_go         <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_go    <= in_xfer && (i_in_data.op == pfa_pkg::OP_ALLOC);
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    pfa_pkg::CFG_FIT_MODE:   r_fit_mode   <= i_cfg_data[1:0];
                    pfa_pkg::CFG_NUM_BLOCKS: r_num_blocks <= i_cfg_data[4:0];
                    default: ;
                endcase
            end
            if (finish) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer && (i_in_data.op == pfa_pkg::OP_ALLOC)) begin
            r_req <= SIZE_WIDTH'(i_in_data.request_size);
        end
        if (finish) begin
            if (c_cand[MAX_BLOCKS].found) begin
                r_out_data.granted       <= 1'b1;
                r_out_data.block_number  <= 4'(c_idx[MAX_BLOCKS]);
                r_out_data.fragmentation <= 16'(frag_full);
            end else begin
                r_out_data.granted       <= 1'b0;
                r_out_data.block_number  <= '0;
                r_out_data.fragmentation <= '0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

FILE: tb/tb_partition_fit_allocator.sv
module tb_partition_fit_allocator;

    // The table depth and the settle wait that follows the last owed result.
    localparam int TBL_DEPTH      = 16;
    localparam int SETTLE_CYCLES  = TBL_DEPTH + 8;
    localparam int IDLE_PCT       = 8;
    localparam int RAND_PHASES    = 12;
    localparam int ITEMS_PER_PHASE = 162;
    localparam int CALM_PHASE     = 5;
    localparam int RUN_LIMIT      = 4_000_000;

    // Codes that the package leaves unnamed. The block ignores them, or treats
    // them as first fit in the case of the fit mode.
    localparam logic [1:0]                    OP_SPARE    = 2'd3;
    localparam logic [1:0]                    FIT_SPARE   = 2'd3;
    localparam logic [pfa_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [pfa_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    logic                           i_clk       = 1'b0;
    logic                           i_rst_n     = 1'b0;
    logic                           i_in_valid  = 1'b0;
    logic                           o_in_stall;
    pfa_pkg::t_in_item              i_in_data   = '0;
    logic                           o_out_valid;
    logic                           i_out_stall = 1'b0;
    pfa_pkg::t_out_item             o_out_data;
    logic                           i_cfg_valid = 1'b0;
    logic                           o_cfg_ready;
    logic [pfa_pkg::CFG_IDX_W-1:0]  i_cfg_index = pfa_pkg::CFG_FIT_MODE;
    logic [pfa_pkg::CFG_DATA_W-1:0] i_cfg_data  = '0;

    // Our own copy of the allocator state and of its two registers.
    logic [15:0]          tbl_size [TBL_DEPTH];
    bit [TBL_DEPTH-1:0]   in_use;
    logic [1:0]           fit_sel;
    logic [4:0]           blk_count;

    // Grants and refusals that are owed by the block, oldest first.
    pfa_pkg::t_out_item   grant_q [$];
    pfa_pkg::t_out_item   want_res;

    int                   fails = 0;
    // While this is set, neither side idles, so requests run back to back.
    bit                   calm = 1'b0;

    partition_fit_allocator u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // Works out what one accepted item does to the table and, for a request,
    // which block it gets. In first fit the first match is kept, since only the
    // worst and best fit modes ever replace the pick.
    function automatic void predict_allocation(input pfa_pkg::t_in_item it);
        int                 lim;
        int                 pick;
        bit                 found;
        pfa_pkg::t_out_item res;
        found = 1'b0;
        pick  = 0;
        res   = '0;
        case (it.op)
            pfa_pkg::OP_LOAD: begin
                // The used flag of the entry stays as it is.
                tbl_size[it.block_index] = it.block_size;
            end
            pfa_pkg::OP_CLEAR: begin
                in_use = '0;
            end
            pfa_pkg::OP_ALLOC: begin
                // A block count above the table depth saturates.
                lim = (blk_count > TBL_DEPTH) ? TBL_DEPTH : int'(blk_count);
                for (int j = 0; j < lim; j++) begin
                    if (!in_use[j] && tbl_size[j] >= it.request_size) begin
                        if (!found) begin
                            found = 1'b1;
                            pick  = j;
                        end else if (fit_sel == pfa_pkg::FIT_WORST &&
                                     tbl_size[j] > tbl_size[pick]) begin
                            pick = j;
                        end else if (fit_sel == pfa_pkg::FIT_BEST &&
                                     tbl_size[j] < tbl_size[pick]) begin
                            pick = j;
                        end
                    end
                end
                if (found) begin
                    in_use[pick]      = 1'b1;
                    res.granted       = 1'b1;
                    res.block_number  = pick[3:0];
                    res.fragmentation = tbl_size[pick] - it.request_size;
                end
                grant_q.push_back(res);
            end
            default: begin
                // The spare op code is dropped without a result.
            end
        endcase
    endfunction

    function automatic pfa_pkg::t_in_item mk_item(input logic [1:0] op,
                                                  input logic [3:0] idx,
                                                  input logic [15:0] bsize,
                                                  input logic [15:0] req);
        pfa_pkg::t_in_item it;
        it.op           = op;
        it.block_index  = idx;
        it.block_size   = bsize;
        it.request_size = req;
        return it;
    endfunction

    // Block sizes lean toward small values so that requests often fit, with the
    // extremes and the full range mixed in.
    function automatic logic [15:0] rand_block_size();
        case ($urandom_range(9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2, 3:    return 16'($urandom_range(65535));
            default: return 16'($urandom_range(1000));
        endcase
    endfunction

    // Requests sometimes match a table entry exactly, which gives zero
    // fragmentation and exercises the ties.
    function automatic logic [15:0] rand_request();
        case ($urandom_range(9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(65535));
            3:       return tbl_size[$urandom_range(TBL_DEPTH - 1)];
            default: return 16'($urandom_range(1000));
        endcase
    endfunction

    // Presents one item and holds it until the transfer. Valid is only dropped
    // for an idle gap, never in the step in which it has to stay high.
    task automatic send_item(input pfa_pkg::t_in_item it);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        predict_allocation(it);
    endtask

    // Drops valid and waits until every owed result is back. The extra cycles
    // cover a load or clear still in flight, since those give no result.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (grant_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [pfa_pkg::CFG_IDX_W-1:0] idx,
                              input logic [pfa_pkg::CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        case (idx)
            pfa_pkg::CFG_FIT_MODE:   fit_sel = val[1:0];
            pfa_pkg::CFG_NUM_BLOCKS: blk_count = val;
            default: ;
        endcase
    endtask

    // Every entry is loaded before the first request, so no scan can reach an
    // entry that was never written. The sizes include both extremes.
    task automatic test_load_table();
        logic [15:0] sizes [TBL_DEPTH];
        sizes = '{16'd0, 16'd100, 16'd65535, 16'd50, 16'd200, 16'd100, 16'd300, 16'd8,
                  16'd4096, 16'd65535, 16'd1, 16'd12345, 16'd200, 16'd32768, 16'd7,
                  16'd65535};
        for (int k = 0; k < TBL_DEPTH; k++) begin
            send_item(mk_item(pfa_pkg::OP_LOAD, 4'(k), sizes[k],
                              16'($urandom_range(65535))));
        end
    endtask

    task automatic test_first_fit();
        // A zero request takes the empty block at index zero.
        send_item(mk_item(pfa_pkg::OP_ALLOC, 4'd0, 16'd0, 16'd0));
        send_item(mk_item(pfa_pkg::OP_ALLOC, 4'd0, 16'd0, 16'hFFFF));
        send_item(mk_item(pfa_pkg::OP_ALLOC, 4'd0, 16'd0, 16'hFFFF));
        // Reloading a block in use must leave it in use.
        send_item(mk_item(pfa_pkg::OP_LOAD, 4'd9, 16'd500, 16'd0));
        send_item(mk_item(pfa_pkg::OP_ALLOC, 4'hF, 16'hFFFF, 16'd400));
        send_item(mk_item(pfa_pkg::OP_ALLOC, 4'd0, 16'd0, 16'hFFFF));
        // All the largest blocks are gone now, so this one is refused.
        send_item(mk_item(pfa_pkg::OP_ALLOC, 4'd0, 16'd0, 16'hFFFF));
        send_item(mk_item(OP_SPARE, 4'($urandom_range(15)), 16'hFFFF, 16'hFFFF));
        send_item(mk_item(pfa_pkg::OP_CLEAR, 4'hF, 16'hFFFF, 16'hFFFF));
    endtask

    task automatic test_worst_fit();
        wait_idle();
        set_config(pfa_pkg::CFG_FIT_MODE, {3'b000, pfa_pkg::FIT_WORST});
        // Two blocks share the largest size; the lower index has to win.
        send_item(mk_item(pfa_pkg::OP_ALLOC, 4'd0, 16'd0, 16'd10));
        send_item(mk_item(pfa_pkg::OP_ALLOC, 4'd0, 16'd0, 16'd32768));
        send_item(mk_item(pfa_pkg::OP_ALLOC, 4'd0, 16'd0, 16'd5));
    endtask

    task automatic test_best_fit();
        wait_idle();
        set_config(pfa_pkg::CFG_FIT_MODE, {3'b111, pfa_pkg::FIT_BEST});
        send_item(mk_item(pfa_pkg::OP_CLEAR, 4'd0, 16'd0, 16'd0));
        // Two blocks of the same smallest fitting size: the lower index wins.
        send_item(mk_item(pfa_pkg::OP_ALLOC, 4'd0, 16'd0, 16'd100));
        send_item(mk_item(pfa_pkg::OP_ALLOC, 4'd0, 16'd0, 16'd9));
    endtask

    task automatic test_mode_and_count_edges();
        wait_idle();
        // The unused fit mode code must behave as first fit.
        set_config(pfa_pkg::CFG_FIT_MODE, {3'b101, FIT_SPARE});
        send_item(mk_item(pfa_pkg::OP_ALLOC, 4'd0, 16'd0, 16'd1));
        wait_idle();
        // With a block count of zero every request is refused.
        set_config(pfa_pkg::CFG_NUM_BLOCKS, 5'd0);
        send_item(mk_item(pfa_pkg::OP_ALLOC, 4'd0, 16'd0, 16'd0));
        wait_idle();
        // A count above the table depth saturates to the full table.
        set_config(pfa_pkg::CFG_NUM_BLOCKS, 5'd31);
        send_item(mk_item(pfa_pkg::OP_ALLOC, 4'd0, 16'd0, 16'hFFFF));
        wait_idle();
        set_config(pfa_pkg::CFG_NUM_BLOCKS, 5'd1);
        send_item(mk_item(pfa_pkg::OP_CLEAR, 4'd0, 16'd0, 16'd0));
        send_item(mk_item(pfa_pkg::OP_ALLOC, 4'd0, 16'd0, 16'd0));
        send_item(mk_item(pfa_pkg::OP_ALLOC, 4'd0, 16'd0, 16'd0));
    endtask

    // Each phase picks a fit mode and a block count, then sends runs that start
    // with a clear and are mostly requests, with loads, clears and stray codes mixed in.
    task automatic test_random_runs();
        int                             sent;
        int                             run_left;
        int                             r;
        logic [pfa_pkg::CFG_DATA_W-1:0] d;
        logic [1:0]                     op;
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            wait_idle();
            calm = (ph == CALM_PHASE);
            d = pfa_pkg::CFG_DATA_W'($urandom_range(31));
            case (ph % 4)
                0:       d[1:0] = pfa_pkg::FIT_FIRST;
                1:       d[1:0] = pfa_pkg::FIT_WORST;
                2:       d[1:0] = pfa_pkg::FIT_BEST;
                default: d[1:0] = FIT_SPARE;
            endcase
            set_config(pfa_pkg::CFG_FIT_MODE, d);
            case (ph % 6)
                0:       d = 5'd16;
                1:       d = 5'd0;
                2:       d = 5'd1;
                3:       d = pfa_pkg::CFG_DATA_W'($urandom_range(17, 31));
                default: d = pfa_pkg::CFG_DATA_W'($urandom_range(2, 15));
            endcase
            set_config(pfa_pkg::CFG_NUM_BLOCKS, d);
            // Writes to the unused register indexes must change nothing.
            if (ph % 5 == 2) begin
                set_config((ph % 2 != 0) ? CFG_SPARE_A : CFG_SPARE_B,
                           pfa_pkg::CFG_DATA_W'($urandom_range(31)));
            end
            sent     = 0;
            run_left = 0;
            while (sent < ITEMS_PER_PHASE) begin
                if (run_left == 0) begin
                    op       = pfa_pkg::OP_CLEAR;
                    run_left = $urandom_range(4, 24);
                end else begin
                    r = $urandom_range(99);
                    if (r < 75)      op = pfa_pkg::OP_ALLOC;
                    else if (r < 92) op = pfa_pkg::OP_LOAD;
                    else if (r < 97) op = pfa_pkg::OP_CLEAR;
                    else             op = OP_SPARE;
                    run_left--;
                end
                send_item(mk_item(op, 4'($urandom_range(15)), rand_block_size(),
                                  rand_request()));
                sent++;
            end
        end
        calm = 1'b0;
    endtask

    // The result side stalls at random, except in the calm stretch.
    always @(posedge i_clk) begin
        i_out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    end

    // Each result transfer is matched against the oldest owed result.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (grant_q.size() == 0) begin
                $error("result transfer with none owed: granted %0d block %0d frag %0d",
                       o_out_data.granted, o_out_data.block_number,
                       o_out_data.fragmentation);
                fails++;
            end else begin
                want_res = grant_q.pop_front();
                if (o_out_data.granted !== want_res.granted) begin
                    $error("granted: expected %0d, got %0d",
                           want_res.granted, o_out_data.granted);
                    fails++;
                end
                if (o_out_data.block_number !== want_res.block_number) begin
                    $error("block_number: expected %0d, got %0d",
                           want_res.block_number, o_out_data.block_number);
                    fails++;
                end
                if (o_out_data.fragmentation !== want_res.fragmentation) begin
                    $error("fragmentation: expected %0d, got %0d",
                           want_res.fragmentation, o_out_data.fragmentation);
                    fails++;
                end
            end
        end
    end

    // The main sequence: reset once, the directed tests, then the random runs.
    initial begin
        for (int k = 0; k < TBL_DEPTH; k++) begin
            tbl_size[k] = '0;
        end
        in_use    = '0;
        fit_sel   = pfa_pkg::FIT_FIRST;
        blk_count = 5'd16;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_load_table();
        test_first_fit();
        test_worst_fit();
        test_best_fit();
        test_mode_and_count_edges();
        test_random_runs();

        wait_idle();
        if (fails == 0) begin
            $display("tb_partition_fit_allocator passed");
        end else begin
            $display("tb_partition_fit_allocator failed");
        end
        $finish;
    end

    // Watchdog for a hung handshake; far beyond the slowest correct run.
    initial begin
        #(RUN_LIMIT);
        $display("tb_partition_fit_allocator failed");
        $finish;
    end

endmodule
